// ----- src/lprd_pkg.sv -----
// -----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants for the length-prefixed record deframer.
// -----------------------------------------------------------------------------
package lprd_pkg;

   localparam int unsigned MAX_SYMBOL_SIZE  = 4096;
   localparam int unsigned SIZE_WIDTH       = 13;
   localparam int unsigned OFFSET_WIDTH     = 12;
   localparam int unsigned LENGTH_WIDTH     = 16;
   localparam int unsigned BYTE_WIDTH       = 8;
   localparam int unsigned CSR_INDEX_WIDTH  = 4;
   localparam int unsigned CSR_DATA_WIDTH   = 16;
   localparam int unsigned HEADER_BYTES     = 2;

   localparam logic [SIZE_WIDTH-1:0]   MIN_SIZE       = SIZE_WIDTH'(HEADER_BYTES);
   localparam logic [SIZE_WIDTH-1:0]   MAX_SIZE       = SIZE_WIDTH'(MAX_SYMBOL_SIZE);
   localparam logic [SIZE_WIDTH-1:0]   SIZE_RESET     = SIZE_WIDTH'(1024);
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET   = LENGTH_WIDTH'(256);
   localparam logic [LENGTH_WIDTH-1:0] HEADER_LENGTH  = LENGTH_WIDTH'(HEADER_BYTES);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOL_SIZE   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECORD_LENGTH = CSR_INDEX_WIDTH'(1);

   typedef enum logic [3:0] {
      PHASE_WAIT    = 4'b0001,
      PHASE_HIGH    = 4'b0010,
      PHASE_PAYLOAD = 4'b0100,
      PHASE_SKIP    = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic [OFFSET_WIDTH-1:0]  offset;
      logic [LENGTH_WIDTH-1:0]  remaining;
      logic [BYTE_WIDTH-1:0]    header_low;
   } parse_state_type;

   typedef struct packed {
      logic                     valid;
      logic [BYTE_WIDTH-1:0]    payload_byte;
      logic                     last_of_record;
      logic                     bad_length;
   } result_type;

endpackage

// ----- src/lprd_parse.sv -----
// -----------------------------------------------------------------------------
// lprd_parse
// One-byte step of the deframer: next parse state and the optional result.
// -----------------------------------------------------------------------------
module lprd_parse (
   input  lprd_pkg::parse_state_type                state_cur,
   input  logic [lprd_pkg::BYTE_WIDTH-1:0]          data_byte,
   input  logic [lprd_pkg::SIZE_WIDTH-1:0]          symbol_size,
   input  logic [lprd_pkg::LENGTH_WIDTH-1:0]        record_length,
   output lprd_pkg::parse_state_type                state_nxt,
   output lprd_pkg::result_type                     result
);
   import lprd_pkg::*;

   logic [SIZE_WIDTH-1:0]   eff_size;
   logic [SIZE_WIDTH-1:0]   offset_plus;
   logic                    at_end;
   logic [LENGTH_WIDTH-1:0] header_len;
   logic [LENGTH_WIDTH-1:0] remaining_dec;
   phase_type               phase_mid;

   always_comb begin
      if (symbol_size < MIN_SIZE) begin
         eff_size = MIN_SIZE;
      end else if (symbol_size > MAX_SIZE) begin
         eff_size = MAX_SIZE;
      end else begin
         eff_size = symbol_size;
      end
   end

   assign offset_plus   = {1'b0, state_cur.offset} + SIZE_WIDTH'(1);
   assign at_end        = (offset_plus >= eff_size);
   assign header_len    = {data_byte, state_cur.header_low};
   assign remaining_dec = state_cur.remaining - LENGTH_WIDTH'(1);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      phase_mid = state_cur.phase;
      unique case (state_cur.phase)
         PHASE_WAIT: begin
            if (!at_end) begin
               state_nxt.header_low = data_byte;
               phase_mid            = PHASE_HIGH;
            end
         end
         PHASE_HIGH: begin
            if (header_len == '0) begin
               phase_mid = PHASE_SKIP;
            end else if (header_len != record_length) begin
               result.valid      = 1'b1;
               result.bad_length = 1'b1;
               phase_mid         = PHASE_SKIP;
            end else if (header_len <= HEADER_LENGTH) begin
               state_nxt.remaining = '0;
               phase_mid           = PHASE_WAIT;
            end else begin
               state_nxt.remaining = header_len - HEADER_LENGTH;
               phase_mid           = PHASE_PAYLOAD;
            end
         end
         PHASE_PAYLOAD: begin
            state_nxt.remaining   = remaining_dec;
            result.valid          = 1'b1;
            result.payload_byte   = data_byte;
            result.last_of_record = (remaining_dec == '0);
            if (remaining_dec == '0) begin
               phase_mid = PHASE_WAIT;
            end
         end
         PHASE_SKIP: begin
            phase_mid = PHASE_SKIP;
         end
         default: begin
            phase_mid = PHASE_WAIT;
         end
      endcase

      if (at_end) begin
         state_nxt.offset = '0;
         state_nxt.phase  = (phase_mid == PHASE_SKIP) ? PHASE_WAIT : phase_mid;
      end else begin
         state_nxt.offset = offset_plus[OFFSET_WIDTH-1:0];
         state_nxt.phase  = phase_mid;
      end
   end

endmodule

// ----- src/length_prefixed_record_deframer_core.sv -----
// -----------------------------------------------------------------------------
// length_prefixed_record_deframer_core
// Splits a byte stream of fixed-size symbols into length-prefixed records.
// -----------------------------------------------------------------------------
// The block takes one byte per clock cycle while req_stall is low and gives
// at most one result per byte in the next cycle: a payload byte
// (last_of_record on the final one) or a bad_length marker. The whole per-byte
// step is one counter and header update between the parse state registers and
// the result register, so the sustained rate is one byte per cycle; req_stall
// rises only while the result register holds a result and rsp_stall is high.
// Write symbol_size and record_length only while the block is idle.
module length_prefixed_record_deframer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lprd_pkg::BYTE_WIDTH-1:0]        req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lprd_pkg::BYTE_WIDTH-1:0]        rsp_payload_byte,
   output logic                                   rsp_last_of_record,
   output logic                                   rsp_bad_length,
   input  logic                                   csr_write_enable,
   input  logic [lprd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lprd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import lprd_pkg::*;

   logic [SIZE_WIDTH-1:0]   symbol_size_ff;
   logic [LENGTH_WIDTH-1:0] record_length_ff;
   parse_state_type         state_ff;
   parse_state_type         state_in;
   result_type              step_result;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [BYTE_WIDTH-1:0]   out_byte_ff;
   logic                    out_last_ff;
   logic                    out_bad_ff;
   logic                    accept;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   lprd_parse u_parse (
      .state_cur     (state_ff),
      .data_byte     (req_data_byte),
      .symbol_size   (symbol_size_ff),
      .record_length (record_length_ff),
      .state_nxt     (state_in),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_size_ff   <= SIZE_RESET;
         record_length_ff <= LENGTH_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SYMBOL_SIZE) begin
            symbol_size_ff <= csr_write_data[SIZE_WIDTH-1:0];
         end else if (csr_index == CSR_RECORD_LENGTH) begin
            record_length_ff <= csr_write_data[LENGTH_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PHASE_WAIT;
         state_ff.offset     <= '0;
         state_ff.remaining  <= '0;
         state_ff.header_low <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      if (accept) begin
         out_valid_in = step_result.valid;
      end else begin
         out_valid_in = out_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.valid) begin
         out_byte_ff <= step_result.payload_byte;
         out_last_ff <= step_result.last_of_record;
         out_bad_ff  <= step_result.bad_length;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_last_of_record = out_last_ff;
   assign rsp_bad_length     = out_bad_ff;

endmodule

// ----- src/lprd_checker.sv -----
// -----------------------------------------------------------------------------
// lprd_checker
// Port-level checks for the deframer core, bound to the top level.
// -----------------------------------------------------------------------------
module lprd_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [lprd_pkg::BYTE_WIDTH-1:0]        rsp_payload_byte,
   input  logic                                   rsp_last_of_record,
   input  logic                                   rsp_bad_length
);
   import lprd_pkg::*;

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_error_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_length) |-> (!rsp_last_of_record && rsp_payload_byte == '0))
      else $error("bad_length result carries payload or last flag");

   a_result_needs_input: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) ##1 rsp_valid |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted transfer");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_last_of_record) && $stable(rsp_bad_length)))
      else $error("stalled result changed");

endmodule

bind length_prefixed_record_deframer_core lprd_checker u_lprd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_last_of_record (rsp_last_of_record),
   .rsp_bad_length     (rsp_bad_length)
);

// ----- tb/sv/length_prefixed_record_deframer_core_tb.sv -----
// -----------------------------------------------------------------------------
// length_prefixed_record_deframer_core_tb
// Self-checking bench for the record deframer. A scoreboard class tracks the
// symbol offset, header and remaining record length of the parser. For every
// byte transfer into the block it queues any payload byte or length error
// that the block owes, and it matches each result transfer against that queue.
// A random stream and a short directed stream open the run. Random record
// streams then follow under many symbol size and record length settings, with
// random idle gaps and stalls, one long receiver hold-off and drained pauses.
// -----------------------------------------------------------------------------
module length_prefixed_record_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lprd_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned HOLD_CYCLES    = 50;
   localparam int unsigned LONGEST_RECORD = 300;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_SPARE = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_SPARE  = '1;

   class deframer_scoreboard;
      logic [SIZE_WIDTH-1:0]   symbol_size   = SIZE_RESET;
      logic [LENGTH_WIDTH-1:0] record_length = LENGTH_RESET;
      logic [OFFSET_WIDTH-1:0] offset        = '0;
      logic [LENGTH_WIDTH-1:0] remaining     = '0;
      logic [BYTE_WIDTH-1:0]   header_low    = '0;
      phase_type               phase         = PHASE_WAIT;
      result_type              owed_results[$];
      int unsigned             mismatches    = 0;

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_SYMBOL_SIZE:   symbol_size = value[SIZE_WIDTH-1:0];
            CSR_RECORD_LENGTH: record_length = value[LENGTH_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function bit at_symbol_end();
         int unsigned size;
         size = symbol_size;
         if (size < MIN_SIZE) size = MIN_SIZE;
         if (size > MAX_SIZE) size = MAX_SIZE;
         return 32'(offset) + 32'd1 >= size;
      endfunction

      function void note_byte(logic [BYTE_WIDTH-1:0] value);
         logic                    at_end;
         logic [LENGTH_WIDTH-1:0] header_length;
         result_type              due;
         at_end = at_symbol_end();
         due = '0;
         due.valid = 1'b1;
         case (phase)
            PHASE_WAIT: begin
               if (!at_end) begin
                  header_low = value;
                  phase = PHASE_HIGH;
               end
            end
            PHASE_HIGH: begin
               header_length = {value, header_low};
               if (header_length == '0) begin
                  phase = PHASE_SKIP;
               end else if (header_length != record_length) begin
                  due.bad_length = 1'b1;
                  owed_results.push_back(due);
                  phase = PHASE_SKIP;
               end else if (header_length <= HEADER_LENGTH) begin
                  remaining = '0;
                  phase = PHASE_WAIT;
               end else begin
                  remaining = header_length - HEADER_LENGTH;
                  phase = PHASE_PAYLOAD;
               end
            end
            PHASE_PAYLOAD: begin
               remaining = remaining - 1'b1;
               due.payload_byte = value;
               due.last_of_record = (remaining == '0);
               owed_results.push_back(due);
               if (remaining == '0) phase = PHASE_WAIT;
            end
            default: ;
         endcase
         if (at_end) begin
            offset = '0;
            if (phase == PHASE_SKIP) phase = PHASE_WAIT;
         end else begin
            offset = offset + 1'b1;
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [BYTE_WIDTH-1:0] payload, logic last, logic bad);
         result_type due;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result payload %02h last %0b bad %0b",
                                      payload, last, bad));
            return;
         end
         due = owed_results.pop_front();
         if (payload !== due.payload_byte)
            report_mismatch($sformatf("payload_byte %02h, want %02h",
                                      payload, due.payload_byte));
         if (last !== due.last_of_record)
            report_mismatch($sformatf("last_of_record %0b, want %0b",
                                      last, due.last_of_record));
         if (bad !== due.bad_length)
            report_mismatch($sformatf("bad_length %0b, want %0b", bad, due.bad_length));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_data_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [BYTE_WIDTH-1:0]      rsp_payload_byte;
   logic                       rsp_last_of_record;
   logic                       rsp_bad_length;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   deframer_scoreboard    sb = new;
   bit                    gaps_enabled = 1'b1;
   bit                    receiver_stalls = 1'b1;
   bit                    receiver_hold_request = 1'b0;
   logic [BYTE_WIDTH-1:0] planned_high = '0;

   length_prefixed_record_deframer_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_record (rsp_last_of_record),
      .rsp_bad_length     (rsp_bad_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_payload_byte, rsp_last_of_record, rsp_bad_length);
   end

   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold_request) begin
            receiver_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (stall_left == 0 && receiver_stalls && $urandom_range(0, 99) < 20)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
                                                      : $urandom_range(1, 3);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   initial begin
      #(5_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] value);
      req_valid <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(value);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int unsigned pick;
      int unsigned idle;
      if (!gaps_enabled) return;
      pick = $urandom_range(0, 99);
      idle = (pick < 65) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      sb.write_register(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed headers; padding, near-miss lengths and noise for the rest.
   function automatic logic [BYTE_WIDTH-1:0] next_stream_byte();
      logic [LENGTH_WIDTH-1:0] header;
      logic [LENGTH_WIDTH-1:0] near_miss;
      int unsigned             pick;
      if (sb.phase == PHASE_HIGH) return planned_high;
      if (sb.phase != PHASE_WAIT || sb.at_symbol_end()) return BYTE_WIDTH'($urandom);
      pick = $urandom_range(0, 99);
      near_miss = sb.record_length ^ (LENGTH_WIDTH'(1) << $urandom_range(0, LENGTH_WIDTH - 1));
      if (pick < 70)
         header = (sb.record_length <= LONGEST_RECORD) ? sb.record_length : near_miss;
      else if (pick < 78)
         header = '0;
      else if (pick < 92)
         header = near_miss;
      else
         header = LENGTH_WIDTH'($urandom);
      planned_high = header[15:8];
      return header[7:0];
   endfunction

   task automatic run_items(input int unsigned count);
      repeat (count) begin
         send_byte(next_stream_byte());
         sender_gap();
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_WIDTH-1:0] size,
                            input logic [CSR_DATA_WIDTH-1:0] length,
                            input int unsigned count, input bit press);
      drain();
      write_csr(CSR_SYMBOL_SIZE, size);
      write_csr(CSR_RECORD_LENGTH, length);
      write_csr(CSR_INDEX_WIDTH'($urandom_range(CSR_LAST_SPARE, CSR_FIRST_SPARE)),
                CSR_DATA_WIDTH'($urandom));
      gaps_enabled = !press && ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      receiver_hold_request = press;
      run_items(count);
   endtask

   task automatic run_directed();
      logic [BYTE_WIDTH-1:0] record_stream [15] = '{
         8'h06, 8'h00, 8'h00, 8'hFF, 8'h80,
         8'h01, 8'h00, 8'h00, 8'hAB, 8'hCD,
         8'h34, 8'h12, 8'h55, 8'hAA, 8'h99};
      logic [BYTE_WIDTH-1:0] short_stream [5] = '{8'h02, 8'h00, 8'h02, 8'h00, 8'h7F};
      drain();
      write_csr(CSR_SYMBOL_SIZE, CSR_DATA_WIDTH'(5));
      write_csr(CSR_RECORD_LENGTH, CSR_DATA_WIDTH'(6));
      foreach (record_stream[i]) begin
         send_byte(record_stream[i]);
         sender_gap();
      end
      drain();
      write_csr(CSR_RECORD_LENGTH, CSR_DATA_WIDTH'(2));
      foreach (short_stream[i]) begin
         send_byte(short_stream[i]);
         sender_gap();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_items(30);
      run_directed();
      run_phase(16'd16, 16'd8, 60, 1'b1);
      run_phase(16'd0, 16'd3, 40, 1'b0);
      run_phase(16'd1, 16'd4, 30, 1'b0);
      run_phase(16'd7, 16'd2, 20, 1'b0);
      drain();
      run_items(20);
      run_phase(16'd9, 16'd1, 30, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 20, 1'b0);
      run_phase(16'd4096, 16'd0, 15, 1'b0);
      run_phase(16'd5, 16'd3, 30, 1'b0);
      run_phase(16'd33, 16'd20, 40, 1'b0);
      run_phase(16'd33, 16'd12, 30, 1'b0);
      run_phase(16'd12, 16'd5, 60, 1'b0);
      run_phase(16'd2, 16'd3, 20, 1'b0);
      run_phase(16'd11, 16'd6, 40, 1'b0);
      drain();

      if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
